>>> rtl/ptq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the priority turn queue.
package ptq_pkg;

   localparam int PTQ_CAPACITY = 16;

   // Request codes
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_SORT   = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_POP    = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_BAD_POS = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [7:0]  team;
   } entry_type;

   typedef enum logic {
      ALU_BUBBLE,
      ALU_SHIFT
   } alu_mode_type;

   typedef struct packed {
      entry_type wr_data;
      entry_type carry;
      logic      swap;
   } alu_res_type;

endpackage

>>> rtl/priority_turn_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the priority turn queue: sequencer, occupancy and result register.
//
//  channel  direction  handshake             payload
//  req      in         req_valid / req_stall  req_type, entry id/priority/team, position
//  rsp      out        rsp_valid / rsp_stall  status, removed entry, count, head
//
// Steps: each request passes an execution step, then a head read when entries remain,
//   and a done step that loads the result; remove grabs the entry at its index, then
//   shifts each later entry down a slot; sort of two or more entries runs bubble passes
//   until a pass moves nothing. The entry store gives one read and one write per cycle.
// Reset clears the sequencer, the occupancy and the result valid flag; the store
//   itself is not cleared, only occupied entries are ever read.
// One request is worked at a time; req_stall is high while it is worked. A finished
//   result waits in the result register while the next request is taken.
module priority_turn_queue_unit #(
   parameter int CAPACITY = ptq_pkg::PTQ_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_entry_id,
   input  logic [7:0]  req_entry_priority,
   input  logic [7:0]  req_entry_team,
   input  logic [4:0]  req_position,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_removed_valid,
   output logic [15:0] rsp_removed_id,
   output logic [7:0]  rsp_removed_priority,
   output logic [7:0]  rsp_removed_team,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_head_valid,
   output logic [15:0] rsp_head_id
);
   import ptq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SORT_FIRST,
      ST_SORT_PASS,
      ST_SORT_TAIL,
      ST_REM_GRAB,
      ST_REM_SHIFT,
      ST_HEAD_READ,
      ST_HEAD_WAIT,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [1:0]       req_type_ff;
   entry_type        entry_ff;
   logic [4:0]       pos_ff;
   logic [CNT_W-1:0] occ_ff;
   logic [IDX_W-1:0] idx_ff;
   entry_type        carry_ff;
   logic             swapped_ff;

   // result of the request being worked
   logic [1:0]       status_ff;
   logic             rem_valid_ff;
   entry_type        rem_ff;
   logic             head_valid_ff;
   logic [15:0]      head_id_ff;

   // result register facing the response channel
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic             rsp_rem_valid_ff;
   entry_type        rsp_rem_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_head_valid_ff;
   logic [15:0]      rsp_head_id_ff;

   // store and shared unit hookup
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_rdata;
   alu_mode_type     alu_mode;
   alu_res_type      alu_res;

   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] rem_idx;
   logic [IDX_W-1:0] idx_nx;
   logic             full;
   logic             bad_pos;
   logic             rsp_free;
   logic [31:0]      count_wide;

   ptq_mem #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ptq_alu u_alu (
      .mode     (alu_mode),
      .carry    (carry_ff),
      .incoming (mem_rdata),
      .res      (alu_res)
   );

   assign last_idx = IDX_W'(occ_ff - CNT_W'(1));
   assign rem_idx  = (req_type_ff == REQ_POP) ? '0 : IDX_W'(pos_ff - 5'd1);
   assign idx_nx   = idx_ff + IDX_W'(1);
   assign full     = occ_ff == CNT_W'(CAPACITY);
   assign bad_pos  = (pos_ff == '0) || (32'(pos_ff) > 32'(occ_ff));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // store addressing per sequencer step
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = alu_res.wr_data;
      mem_raddr = '0;
      alu_mode  = ALU_BUBBLE;
      unique case (state_ff)
         ST_EXEC: begin
            if (req_type_ff == REQ_APPEND) begin
               mem_we    = !full;
               mem_waddr = IDX_W'(occ_ff);
               mem_wdata = entry_ff;
            end else if (req_type_ff == REQ_REMOVE || req_type_ff == REQ_POP) begin
               mem_raddr = rem_idx;
            end
         end
         ST_SORT_FIRST: mem_raddr = IDX_W'(1);
         ST_SORT_PASS: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff - IDX_W'(1);
            mem_raddr = idx_nx;
         end
         ST_SORT_TAIL: begin
            mem_we    = 1'b1;
            mem_waddr = last_idx;
            mem_wdata = carry_ff;
         end
         ST_REM_GRAB: mem_raddr = idx_nx;
         ST_REM_SHIFT: begin
            alu_mode  = ALU_SHIFT;
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_raddr = idx_nx + IDX_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result loaded in ST_DONE takes the place of the one leaving
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_type_ff <= req_type;
                  entry_ff    <= '{id: req_entry_id, prio: req_entry_priority,
                                   team: req_entry_team};
                  pos_ff      <= req_position;
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rem_ff <= '0;
               idx_ff <= rem_idx;
               priority if (req_type_ff == REQ_APPEND) begin
                  rem_valid_ff <= 1'b0;
                  state_ff     <= ST_HEAD_READ;
                  if (full) begin
                     status_ff <= STAT_FULL;
                  end else begin
                     status_ff <= STAT_OK;
                     occ_ff    <= occ_ff + CNT_W'(1);
                  end
               end else if (req_type_ff == REQ_SORT) begin
                  // store read of slot 0 is already under way
                  status_ff    <= STAT_OK;
                  rem_valid_ff <= 1'b0;
                  state_ff     <= (occ_ff > CNT_W'(1)) ? ST_SORT_FIRST : ST_HEAD_READ;
               end else if (occ_ff == '0) begin
                  status_ff    <= STAT_EMPTY;
                  rem_valid_ff <= 1'b0;
                  state_ff     <= ST_HEAD_READ;
               end else if (req_type_ff == REQ_REMOVE && bad_pos) begin
                  status_ff    <= STAT_BAD_POS;
                  rem_valid_ff <= 1'b0;
                  state_ff     <= ST_HEAD_READ;
               end else begin
                  status_ff    <= STAT_OK;
                  rem_valid_ff <= 1'b1;
                  state_ff     <= ST_REM_GRAB;
               end
            end
            ST_SORT_FIRST: begin
               carry_ff   <= mem_rdata;
               swapped_ff <= 1'b0;
               idx_ff     <= IDX_W'(1);
               state_ff   <= ST_SORT_PASS;
            end
            ST_SORT_PASS: begin
               carry_ff   <= alu_res.carry;
               swapped_ff <= swapped_ff | alu_res.swap;
               idx_ff     <= idx_nx;
               if (idx_ff == last_idx) state_ff <= ST_SORT_TAIL;
            end
            ST_SORT_TAIL: begin
               // another pass while anything moved; slot 0 read issued here
               state_ff <= swapped_ff ? ST_SORT_FIRST : ST_HEAD_READ;
            end
            ST_REM_GRAB: begin
               rem_ff <= mem_rdata;
               if (idx_ff == last_idx) begin
                  occ_ff   <= occ_ff - CNT_W'(1);
                  state_ff <= ST_HEAD_READ;
               end else begin
                  state_ff <= ST_REM_SHIFT;
               end
            end
            ST_REM_SHIFT: begin
               idx_ff <= idx_nx;
               if (idx_nx == last_idx) begin
                  occ_ff   <= occ_ff - CNT_W'(1);
                  state_ff <= ST_HEAD_READ;
               end
            end
            ST_HEAD_READ: begin
               head_valid_ff <= occ_ff != '0;
               head_id_ff    <= '0;
               state_ff      <= (occ_ff != '0) ? ST_HEAD_WAIT : ST_DONE;
            end
            ST_HEAD_WAIT: begin
               head_id_ff <= mem_rdata.id;
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_status_ff     <= status_ff;
                  rsp_rem_valid_ff  <= rem_valid_ff;
                  rsp_rem_ff        <= rem_ff;
                  rsp_count_ff      <= occ_ff;
                  rsp_head_valid_ff <= head_valid_ff;
                  rsp_head_id_ff    <= head_id_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall  = state_ff != ST_IDLE;
   assign count_wide = 32'(rsp_count_ff);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_valid    = rsp_rem_valid_ff;
   assign rsp_removed_id       = rsp_rem_ff.id;
   assign rsp_removed_priority = rsp_rem_ff.prio;
   assign rsp_removed_team     = rsp_rem_ff.team;
   assign rsp_entry_count      = count_wide[4:0];
   assign rsp_head_valid       = rsp_head_valid_ff;
   assign rsp_head_id          = rsp_head_id_ff;

`ifndef SYNTHESIS
   // occupancy never runs past the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   // an accepted request always starts its execution step
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_EXEC)
      else $error("accepted request not executed");

   // a removed entry only comes with an ok status
   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed_valid |-> rsp_status == STAT_OK)
      else $error("removed entry with failing status");

   // reported head follows the count carried with it
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_head_valid == (rsp_count_ff != '0))
      else $error("head flag disagrees with count");
`endif

endmodule

>>> rtl/ptq_mem.sv
`timescale 1ns / 1ps
// Entry store: one write port, one registered read port.
module ptq_mem #(
   parameter int CAPACITY = ptq_pkg::PTQ_CAPACITY,
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  ptq_pkg::entry_type  wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output ptq_pkg::entry_type  rd_data
);
   import ptq_pkg::*;

   entry_type slots_ff [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slots_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ptq_alu.sv
`timescale 1ns / 1ps
// Shared compare/select unit: one bubble step or one shift step per use.
module ptq_alu (
   input  ptq_pkg::alu_mode_type mode,
   input  ptq_pkg::entry_type    carry,
   input  ptq_pkg::entry_type    incoming,
   output ptq_pkg::alu_res_type  res
);
   import ptq_pkg::*;

   logic greater;

   // strictly greater only, so equal priorities keep arrival order
   assign greater = incoming.prio > carry.prio;

   always_comb begin
      res = '0;
      unique case (mode)
         ALU_BUBBLE: begin
            res.swap    = greater;
            res.wr_data = greater ? incoming : carry;
            res.carry   = greater ? carry : incoming;
         end
         ALU_SHIFT: begin
            res.swap    = 1'b0;
            res.wr_data = incoming;
            res.carry   = carry;
         end
         default: res = '0;
      endcase
   end

endmodule
